// ===== rtl/core/fixed_block_free_list_allocator_unit_macros.svh =====
// Assertion macros used by the allocator control RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fbfl_pkg.sv =====
// Types, constants and codes for the fixed block free list allocator.
package fbfl_pkg;

    localparam int MAX_BLOCKS  = 256;
    localparam int INDEX_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W      = INDEX_W + 1;
    localparam int COUNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int BYTES_W     = 13;
    localparam int OFFSET_W    = 20;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int MIN_BYTES   = 8;
    localparam int MAX_BYTES   = 4096;

    // Null link: one past the last block
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BYTES = CFG_INDEX_W'(1);

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK            = 2'd0,
        STATUS_OUT_OF_BLOCKS = 2'd1,
        STATUS_INVALID_BLOCK = 2'd2
    } status_t;

    typedef enum logic
    {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    typedef struct packed
    {
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] granted_offset;
        status_t             status;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  free_count;
    } result_t;

    typedef struct packed
    {
        logic    valid;
        result_t result;
    } result_push_t;

    typedef struct packed
    {
        logic               wr_en;
        logic [INDEX_W-1:0] wr_addr;
        logic [LINK_W-1:0]  wr_data;
        logic               rd_en;
        logic [INDEX_W-1:0] rd_addr;
    } link_mem_req_t;

endpackage

// ===== rtl/core/fixed_block_free_list_allocator_unit.sv =====
// Top level of the fixed block free list allocator.
// Hands out equal-sized blocks from a LIFO free list held in a 256-entry link
// RAM; after reset or a block_count write the blocks come out in index order.
// A free, or any refused request, is answered when accepted; a granted
// allocation, from the lookup state after the link RAM's registered read. One
// request is in flight at a time, and a two-entry result queue lets the next
// request be taken while a result still waits on the output. The list is
// usable straight after reset and after a relink: per-entry valid flags stand
// in for the chained reset contents, so there is no clearing pass.
module fixed_block_free_list_allocator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [fbfl_pkg::INDEX_W-1:0]        free_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fbfl_pkg::INDEX_W-1:0]        granted_index,
    output logic [fbfl_pkg::OFFSET_W-1:0]       granted_offset,
    output logic [fbfl_pkg::STATUS_W-1:0]       status,
    output logic [fbfl_pkg::COUNT_W-1:0]        used_count,
    output logic [fbfl_pkg::COUNT_W-1:0]        free_count
);

    import fbfl_pkg::*;

    link_mem_req_t      mem_req;
    logic [LINK_W-1:0]  mem_rd_data;
    result_push_t       push;
    logic               buf_room;
    result_t            out_data;

    fbfl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .free_index  (free_index),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .buf_room    (buf_room),
        .push        (push)
    );

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    fbfl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (buf_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign granted_index  = out_data.granted_index;
    assign granted_offset = out_data.granted_offset;
    assign status         = out_data.status;
    assign used_count     = out_data.used_count;
    assign free_count     = out_data.free_count;

endmodule

// ===== rtl/core/fbfl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fbfl_ctrl.sv =====
// Allocator control: configuration, head and usage tracking, link memory access.
`include "fixed_block_free_list_allocator_unit_macros.svh"

module fbfl_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fbfl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [fbfl_pkg::INDEX_W-1:0]        free_index,
    output fbfl_pkg::link_mem_req_t             mem_req,
    input  logic [fbfl_pkg::LINK_W-1:0]         mem_rd_data,
    input  logic                                buf_room,
    output fbfl_pkg::result_push_t              push
);

    import fbfl_pkg::*;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      block_count_reg, block_count_next;
    logic [BYTES_W-1:0]      block_bytes_reg, block_bytes_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [COUNT_W-1:0]      in_use_reg, in_use_next;
    logic [MAX_BLOCKS-1:0]   link_valid_reg, link_valid_next;

    logic                    accept;
    logic                    is_alloc;
    logic                    alloc_refuse;
    logic                    free_bad;
    logic                    alloc_go;
    logic                    free_go;
    logic [INDEX_W-1:0]      head_idx;
    logic [LINK_W-1:0]       head_plus;
    logic [LINK_W-1:0]       default_link;
    logic [LINK_W-1:0]       link_val;
    logic [INDEX_W+BYTES_W-1:0] product;
    logic [COUNT_W-1:0]      cnt_raw;
    logic [BYTES_W-1:0]      bytes_raw;

    assign head_idx     = head_reg[INDEX_W-1:0];
    assign accept       = in_valid && in_ready;
    assign is_alloc     = (func_t'(func) == FUNC_ALLOC);
    assign alloc_refuse = (head_reg == LINK_NULL) || (head_reg >= block_count_reg)
                          || (in_use_reg >= block_count_reg);
    assign free_bad     = ({1'b0, free_index} >= block_count_reg) || (in_use_reg == '0);
    assign alloc_go     = accept && is_alloc && !alloc_refuse;
    assign free_go      = accept && !is_alloc && !free_bad;

    // An entry never written since the last relink holds its chained default
    assign head_plus    = {1'b0, head_idx} + LINK_W'(1);
    assign default_link = (head_plus < block_count_reg) ? head_plus : LINK_NULL;
    assign link_val     = link_valid_reg[head_idx] ? mem_rd_data : default_link;

    assign product = {{BYTES_W{1'b0}}, head_idx} * {{INDEX_W{1'b0}}, block_bytes_reg};

    assign cnt_raw   = cfg_data[COUNT_W-1:0];
    assign bytes_raw = cfg_data[BYTES_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (alloc_go)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        block_count_next = block_count_reg;
        block_bytes_next = block_bytes_reg;
        head_next        = head_reg;
        in_use_next      = in_use_reg;
        link_valid_next  = link_valid_reg;

        if (state_reg == ST_LOOKUP)
        begin
            head_next   = link_val;
            in_use_next = in_use_reg + COUNT_W'(1);
        end
        else if (free_go)
        begin
            head_next                   = {1'b0, free_index};
            in_use_next                 = in_use_reg - COUNT_W'(1);
            link_valid_next[free_index] = 1'b1;
        end

        if (cfg_we)
        begin
            if (cfg_index == CFG_BLOCK_COUNT)
            begin
                priority if (cnt_raw == '0)
                    block_count_next = COUNT_W'(1);
                else if (cnt_raw > COUNT_W'(MAX_BLOCKS))
                    block_count_next = COUNT_W'(MAX_BLOCKS);
                else
                    block_count_next = cnt_raw;
                // Relink: every entry falls back to its chained default
                head_next       = '0;
                in_use_next     = '0;
                link_valid_next = '0;
            end
            else if (cfg_index == CFG_BLOCK_BYTES)
            begin
                priority if (bytes_raw < BYTES_W'(MIN_BYTES))
                    block_bytes_next = BYTES_W'(MIN_BYTES);
                else if (bytes_raw > BYTES_W'(MAX_BYTES))
                    block_bytes_next = BYTES_W'(MAX_BYTES);
                else
                    block_bytes_next = bytes_raw;
            end
        end
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE) && buf_room;

        mem_req.wr_en   = free_go;
        mem_req.wr_addr = free_index;
        mem_req.wr_data = head_reg;
        mem_req.rd_en   = alloc_go;
        mem_req.rd_addr = head_idx;

        push.valid                 = (state_reg == ST_LOOKUP) || (accept && !alloc_go);
        push.result.granted_index  = '0;
        push.result.granted_offset = '0;
        push.result.status         = STATUS_OK;
        push.result.used_count     = in_use_next;
        push.result.free_count     = block_count_reg - in_use_next;

        if (state_reg == ST_LOOKUP)
        begin
            push.result.granted_index  = head_idx;
            push.result.granted_offset = product[OFFSET_W-1:0];
        end
        else if (accept && is_alloc)
        begin
            push.result.status = STATUS_OUT_OF_BLOCKS;
        end
        else if (accept && free_bad)
        begin
            push.result.status = STATUS_INVALID_BLOCK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= COUNT_W'(MAX_BLOCKS);
            block_bytes_reg <= BYTES_W'(MIN_BYTES);
            head_reg        <= '0;
            in_use_reg      <= '0;
            link_valid_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            block_count_reg <= block_count_next;
            block_bytes_reg <= block_bytes_next;
            head_reg        <= head_next;
            in_use_reg      <= in_use_next;
            link_valid_reg  <= link_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_in_use_bound, clk, rst_n, 1'b1,
        in_use_reg <= block_count_reg, "in_use above block_count")
    `ASSERT_NEXT(a_alloc_lookup, clk, rst_n, mem_req.rd_en,
        state_reg == ST_LOOKUP, "granted alloc did not enter lookup")
    `ASSERT_IMPLIES(a_lookup_head, clk, rst_n, state_reg == ST_LOOKUP,
        head_reg < block_count_reg, "lookup on empty list")
    `ASSERT_IMPLIES(a_push_room, clk, rst_n, push.valid,
        buf_room, "result pushed into full buffer")

endmodule

// ===== rtl/core/fbfl_out_buf.sv =====
// Two-entry result queue that decouples the allocator from the output channel.
module fbfl_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbfl_pkg::result_push_t push,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fbfl_pkg::result_t      out_data
);

    import fbfl_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] level;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign room      = (count_reg != 2'd2);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;
    assign level     = count_reg - {1'b0, pop};

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        // Advance the queue on a transaction, then append behind what remains
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push.valid)
        begin
            if (level == 2'd0)
            begin
                slot0_next = push.result;
            end
            else
            begin
                slot1_next = push.result;
            end
        end
        count_next = level + {1'b0, push.valid};
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule
